### src/yuv_color_effect_pixel_macros.svh
// Assertion macros shared by the color effect RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef YUV_COLOR_EFFECT_PIXEL_MACROS_SVH
`define YUV_COLOR_EFFECT_PIXEL_MACROS_SVH

`ifndef SYNTHESIS
`define YCE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define YCE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define YCE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define YCE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

### src/yce_pkg.sv
// Types, coefficients and arithmetic helpers for the YUV color effect pixel block.
// No dependencies; imported by yuv_color_effect_pixel and the simulation files.
package yce_pkg;

    localparam int PIX_W  = 8;
    localparam int RGB_W  = 11;
    localparam int EFF_W  = 14;
    localparam int ACC_W  = 32;
    localparam int MODE_W = 3;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [RGB_W-1:0] rgb_t;
    typedef logic signed [EFF_W-1:0] eff_t;
    typedef logic [PIX_W-1:0]        pix_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_GRAY   = 3'd0,
        MODE_SEPIA  = 3'd1,
        MODE_COMIC  = 3'd2,
        MODE_INVERT = 3'd3,
        MODE_RED    = 3'd4,
        MODE_PASS   = 3'd5
    } effect_mode_t;

    // Byte address of the effect mode register.
    localparam logic [APB_AW-1:0] ADDR_EFFECT_MODE = 3'd0;

    // YUV to RGB, 14-bit fractions.
    localparam acc_t K_RV = 32'sd22458;
    localparam acc_t K_GU = 32'sd11436;
    localparam acc_t K_GV = 32'sd11520;
    localparam acc_t K_BU = 32'sd28384;

    // Sepia matrix.
    localparam acc_t K_SRR = 32'sd6439;
    localparam acc_t K_SRG = 32'sd12599;
    localparam acc_t K_SRB = 32'sd3097;
    localparam acc_t K_SGR = 32'sd5718;
    localparam acc_t K_SGG = 32'sd11239;
    localparam acc_t K_SGB = 32'sd2753;
    localparam acc_t K_SBR = 32'sd4456;
    localparam acc_t K_SBG = 32'sd8749;
    localparam acc_t K_SBB = 32'sd2146;

    // RGB to YUV.
    localparam acc_t K_YR  = 32'sd4211;
    localparam acc_t K_YG  = 32'sd8258;
    localparam acc_t K_YB  = 32'sd1606;
    localparam acc_t K_UR  = 32'sd2425;
    localparam acc_t K_UG  = 32'sd4768;
    localparam acc_t K_UB  = 32'sd7193;
    localparam acc_t K_VR  = 32'sd7193;
    localparam acc_t K_VG  = 32'sd6029;
    localparam acc_t K_VB  = 32'sd1163;
    localparam acc_t OFS_Y = 32'sd262144;
    localparam acc_t OFS_C = 32'sd2097152;

    // Reciprocal of three in 16-bit fraction, exact for magnitudes below 32768.
    localparam acc_t K_DIV3 = 32'sd21846;

    // Divide by 2^14 with truncation toward zero.
    function automatic acc_t q14(input acc_t v);
        acc_t bias;
        bias = (v < 0) ? 32'sd16383 : 32'sd0;
        return (v + bias) >>> 14;
    endfunction

    // Divide by 256 with truncation toward zero.
    function automatic acc_t q8(input acc_t v);
        acc_t bias;
        bias = (v < 0) ? 32'sd255 : 32'sd0;
        return (v + bias) >>> 8;
    endfunction

    function automatic acc_t abs32(input acc_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic pix_t sat8(input acc_t v);
        pix_t res;
        if (v < 0) begin
            res = '0;
        end else if (v > 32'sd255) begin
            res = '1;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

### src/yuv_color_effect_pixel.sv
// Per-pixel color effect: YUV to RGB, one of six effects, RGB back to saturated YUV.
// Depends on yce_pkg and on yuv_color_effect_pixel_macros.svh for its checks.
//
// The block takes one pixel per clock unless the full pipeline is blocked at the
// output, and returns one pixel per transaction when the output side is ready.
// The four register stages are RGB conversion, effect, YUV weighted sums, and
// rounding with saturation; each stage holds its own valid bit and moves on
// whenever the stage after it is empty or moving, so bubbles close up and the
// input keeps flowing while a finished result waits. The effect mode register
// should be written only while no pixel is in flight; modes 6 and 7 act like mode 5.
`include "yuv_color_effect_pixel_macros.svh"

module yuv_color_effect_pixel (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [yce_pkg::APB_AW-1:0] paddr,
    input  logic [yce_pkg::APB_DW-1:0] pwdata,
    output logic [yce_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [yce_pkg::PIX_W-1:0]  s_luma_in,
    input  logic [yce_pkg::PIX_W-1:0]  s_cb_in,
    input  logic [yce_pkg::PIX_W-1:0]  s_cr_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [yce_pkg::PIX_W-1:0]  m_luma_out,
    output logic [yce_pkg::PIX_W-1:0]  m_cb_out,
    output logic [yce_pkg::PIX_W-1:0]  m_cr_out
);
    import yce_pkg::*;

    effect_mode_t mode_reg, mode_next;
    logic         cfg_wr;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic en1, en2, en3, en4;

    rgb_t r_reg, g_reg, b_reg, r_next, g_next, b_next;
    eff_t nr_reg, ng_reg, nb_reg, nr_next, ng_next, nb_next;
    acc_t sy_reg, su_reg, sv_reg, sy_next, su_next, sv_next;
    pix_t yo_reg, uo_reg, vo_reg, yo_next, uo_next, vo_next;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_EFFECT_MODE[2]);

    always_comb begin
        mode_next = mode_reg;
        if (cfg_wr) begin
            mode_next = effect_mode_t'(pwdata[MODE_W-1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ADDR_EFFECT_MODE[2]) begin
            prdata = {{(APB_DW-MODE_W){1'b0}}, mode_reg};
        end
    end

    // Each stage advances when the next one is empty or advancing itself.
    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    assign v1_next = en1 ? s_valid : v1_reg;
    assign v2_next = en2 ? v1_reg  : v2_reg;
    assign v3_next = en3 ? v2_reg  : v3_reg;
    assign v4_next = en4 ? v3_reg  : v4_reg;

    // Stage 1: YUV to signed, unclamped RGB.
    always_comb begin
        acc_t y_s, d_s, e_s;
        y_s    = $signed({{(ACC_W-PIX_W){1'b0}}, s_luma_in});
        d_s    = $signed({{(ACC_W-PIX_W){1'b0}}, s_cb_in}) - 32'sd128;
        e_s    = $signed({{(ACC_W-PIX_W){1'b0}}, s_cr_in}) - 32'sd128;
        r_next = rgb_t'(q14((y_s <<< 14) + K_RV * e_s));
        g_next = rgb_t'(q14((y_s <<< 14) - K_GU * d_s - K_GV * e_s));
        b_next = rgb_t'(q14((y_s <<< 14) + K_BU * d_s));
    end

    // Stage 2: the selected effect, always reading the original RGB.
    always_comb begin
        acc_t r32, g32, b32, sum, mag, third, tr, tg;
        r32   = acc_t'(r_reg);
        g32   = acc_t'(g_reg);
        b32   = acc_t'(b_reg);
        sum   = r32 + g32 + b32;
        mag   = abs32(sum);
        third = (mag * K_DIV3) >>> 16;
        third = (sum < 0) ? -third : third;
        tr    = abs32((g32 <<< 1) - b32 + r32);
        tg    = abs32((b32 <<< 1) - g32 + r32);
        case (mode_reg)
            MODE_GRAY: begin
                nr_next = eff_t'(third);
                ng_next = eff_t'(third);
                nb_next = eff_t'(third);
            end
            MODE_SEPIA: begin
                nr_next = eff_t'(q14(K_SRR * r32 + K_SRG * g32 + K_SRB * b32));
                ng_next = eff_t'(q14(K_SGR * r32 + K_SGG * g32 + K_SGB * b32));
                nb_next = eff_t'(q14(K_SBR * r32 + K_SBG * g32 + K_SBB * b32));
            end
            MODE_COMIC: begin
                nr_next = eff_t'(q8(tr * r32));
                ng_next = eff_t'(q8(tg * r32));
                nb_next = eff_t'(q8(tg * g32));
            end
            MODE_INVERT: begin
                nr_next = eff_t'(32'sd255 - r32);
                ng_next = eff_t'(32'sd255 - g32);
                nb_next = eff_t'(32'sd255 - b32);
            end
            MODE_RED: begin
                nr_next = eff_t'(r32);
                ng_next = '0;
                nb_next = '0;
            end
            default: begin
                nr_next = eff_t'(r32);
                ng_next = eff_t'(g32);
                nb_next = eff_t'(b32);
            end
        endcase
    end

    // Stage 3: weighted sums back to YUV, offsets included.
    always_comb begin
        acc_t r32, g32, b32;
        r32     = acc_t'(nr_reg);
        g32     = acc_t'(ng_reg);
        b32     = acc_t'(nb_reg);
        sy_next = K_YR * r32 + K_YG * g32 + K_YB * b32 + OFS_Y;
        su_next = K_UB * b32 - K_UR * r32 - K_UG * g32 + OFS_C;
        sv_next = K_VR * r32 - K_VG * g32 - K_VB * b32 + OFS_C;
    end

    // Stage 4: truncate and saturate into the output register.
    assign yo_next = sat8(q14(sy_reg));
    assign uo_next = sat8(q14(su_reg));
    assign vo_next = sat8(q14(sv_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_GRAY;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            v1_reg   <= v1_next;
            v2_reg   <= v2_next;
            v3_reg   <= v3_next;
            v4_reg   <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
        if (en2) begin
            nr_reg <= nr_next;
            ng_reg <= ng_next;
            nb_reg <= nb_next;
        end
        if (en3) begin
            sy_reg <= sy_next;
            su_reg <= su_next;
            sv_reg <= sv_next;
        end
        if (en4) begin
            yo_reg <= yo_next;
            uo_reg <= uo_next;
            vo_reg <= vo_next;
        end
    end

    assign m_valid    = v4_reg;
    assign m_luma_out = yo_reg;
    assign m_cb_out   = uo_reg;
    assign m_cr_out   = vo_reg;

    `YCE_ASSERT_IMP(a_full_stall, aclk, aresetn, !s_ready, m_valid && !m_ready && v1_reg && v2_reg && v3_reg, "input stalled without a full, blocked pipeline")
    `YCE_ASSERT_NXT(a_accept_lands, aclk, aresetn, s_valid && s_ready, v1_reg, "accepted transaction did not reach stage one")
    `YCE_ASSERT_NXT(a_drain_out, aclk, aresetn, v3_reg && en4, m_valid, "stage three result lost on the way out")
    `YCE_ASSERT_NXT(a_mode_write, aclk, aresetn, cfg_wr, mode_reg == $past(pwdata[MODE_W-1:0]), "effect mode write not taken")

endmodule

### sim/yce_pixel_checker.sv
// Checker for the YUV color effect pixel block: tracks the effect mode register,
// predicts each pixel and compares every result transaction in order.
// Depends on yce_pkg for the port widths, the mode codes and the register address.
module yce_pixel_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [yce_pkg::APB_AW-1:0] paddr,
    input  logic [yce_pkg::APB_DW-1:0] pwdata,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  yce_pkg::pix_t              s_luma_in,
    input  yce_pkg::pix_t              s_cb_in,
    input  yce_pkg::pix_t              s_cr_in,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  yce_pkg::pix_t              m_luma_out,
    input  yce_pkg::pix_t              m_cb_out,
    input  yce_pkg::pix_t              m_cr_out,
    output int                         error_count,
    output int                         pending_pixels
);
    timeunit 1ns;
    timeprecision 1ps;

    import yce_pkg::*;

    typedef struct packed {
        pix_t luma;
        pix_t cb;
        pix_t cr;
    } yuv_pixel_t;

    localparam longint FRAC_ONE = 16384;

    logic [MODE_W-1:0] cur_mode;
    yuv_pixel_t        expected_pixels[$];
    yuv_pixel_t        want;

    function automatic pix_t clip_byte(input longint v);
        pix_t res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 255) begin
            res = 8'd255;
        end else begin
            res = pix_t'(v);
        end
        return res;
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // SystemVerilog integer division truncates toward zero, which is exactly
    // the rounding that every weighted sum of the block needs.
    function automatic yuv_pixel_t apply_effect(input pix_t y_s, input pix_t u_s,
                                                input pix_t v_s,
                                                input logic [MODE_W-1:0] mode);
        longint y, d, e, r, g, b, nr, ng, nb, t;
        yuv_pixel_t res;
        y = longint'(y_s);
        d = longint'(u_s) - 128;
        e = longint'(v_s) - 128;
        r = (FRAC_ONE * y + 22458 * e) / FRAC_ONE;
        g = (FRAC_ONE * y - 11436 * d - 11520 * e) / FRAC_ONE;
        b = (FRAC_ONE * y + 28384 * d) / FRAC_ONE;
        case (mode)
            MODE_GRAY: begin
                nr = (r + g + b) / 3;
                ng = nr;
                nb = nr;
            end
            MODE_SEPIA: begin
                nr = (6439 * r + 12599 * g + 3097 * b) / FRAC_ONE;
                ng = (5718 * r + 11239 * g + 2753 * b) / FRAC_ONE;
                nb = (4456 * r + 8749 * g + 2146 * b) / FRAC_ONE;
            end
            MODE_COMIC: begin
                t  = magnitude(b - g + b + r);
                nr = (magnitude(g - b + g + r) * r) / 256;
                ng = (t * r) / 256;
                nb = (t * g) / 256;
            end
            MODE_INVERT: begin
                nr = 255 - r;
                ng = 255 - g;
                nb = 255 - b;
            end
            MODE_RED: begin
                nr = r;
                ng = 0;
                nb = 0;
            end
            default: begin
                nr = r;
                ng = g;
                nb = b;
            end
        endcase
        res.luma = clip_byte((4211 * nr + 8258 * ng + 1606 * nb + 16 * FRAC_ONE)
                             / FRAC_ONE);
        res.cb   = clip_byte((-2425 * nr - 4768 * ng + 7193 * nb + 128 * FRAC_ONE)
                             / FRAC_ONE);
        res.cr   = clip_byte((7193 * nr - 6029 * ng - 1163 * nb + 128 * FRAC_ONE)
                             / FRAC_ONE);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    initial begin
        error_count    = 0;
        pending_pixels = 0;
        cur_mode       = MODE_GRAY;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_mode = MODE_GRAY;
            expected_pixels.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_EFFECT_MODE) begin
                cur_mode = pwdata[MODE_W-1:0];
            end
            if (s_valid && s_ready) begin
                expected_pixels.push_back(apply_effect(s_luma_in, s_cb_in, s_cr_in,
                                                       cur_mode));
            end
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf(
                        "result transaction with no pixel pending (%0d %0d %0d)",
                        m_luma_out, m_cb_out, m_cr_out));
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_luma_out !== want.luma) begin
                        report_mismatch($sformatf("luma_out got %0d expected %0d",
                                                  m_luma_out, want.luma));
                    end
                    if (m_cb_out !== want.cb) begin
                        report_mismatch($sformatf("cb_out got %0d expected %0d",
                                                  m_cb_out, want.cb));
                    end
                    if (m_cr_out !== want.cr) begin
                        report_mismatch($sformatf("cr_out got %0d expected %0d",
                                                  m_cr_out, want.cr));
                    end
                end
            end
        end
        pending_pixels = expected_pixels.size();
    end

endmodule

### sim/tb_yuv_color_effect_pixel.sv
// Top of the color effect testbench: clock, reset, register writes, pixel stimulus
// with random gaps and output stalls, a watchdog and the final verdict.
// Depends on yce_pkg, yuv_color_effect_pixel and yce_pixel_checker.
module tb_yuv_color_effect_pixel;
    timeunit 1ns;
    timeprecision 1ps;

    import yce_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int STALL_LIMIT  = 2000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_PIXELS = 108;

    // Corner pixels as {Y, U, V}: all-zero, all-ones, saturated chroma, mid gray and white.
    localparam logic [23:0] CORNER_PIXELS [8] = '{
        24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00,
        24'hFFFF00, 24'h0000FF, 24'h808080, 24'hFF8080
    };

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid;
    logic              s_ready;
    pix_t              s_luma_in;
    pix_t              s_cb_in;
    pix_t              s_cr_in;
    logic              m_valid;
    logic              m_ready;
    pix_t              m_luma_out;
    pix_t              m_cb_out;
    pix_t              m_cr_out;
    int                error_count;
    int                pending_pixels;
    int                quiet_cycles = 0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    yuv_color_effect_pixel u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_luma_in  (s_luma_in),
        .s_cb_in    (s_cb_in),
        .s_cr_in    (s_cr_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_luma_out (m_luma_out),
        .m_cb_out   (m_cb_out),
        .m_cr_out   (m_cr_out)
    );

    yce_pixel_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_luma_in      (s_luma_in),
        .s_cb_in        (s_cb_in),
        .s_cr_in        (s_cr_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_luma_out     (m_luma_out),
        .m_cb_out       (m_cb_out),
        .m_cr_out       (m_cr_out),
        .error_count    (error_count),
        .pending_pixels (pending_pixels)
    );

    // Mostly no gap, sometimes a few cycles, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Leans on the extremes so that saturation is hit often.
    function automatic pix_t pick_sample();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return 8'd0;
        end else if (roll == 1) begin
            return 8'd255;
        end else if (roll == 2) begin
            return 8'd128;
        end
        return pix_t'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input pix_t y, input pix_t u, input pix_t v, input int gap);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_luma_in <= y;
        s_cb_in   <= u;
        s_cr_in   <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending and let every pixel in flight come out.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_effect_mode(input logic [MODE_W-1:0] mode);
        drain_pipeline();
        apb_write(ADDR_EFFECT_MODE, APB_DW'(mode));
    endtask

    // Output side: bursts of ready, mostly short stalls, now and then a long
    // stretch with no stall at all.
    initial begin
        int burst;
        int stall;
        m_ready = 1'b0;
        forever begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
            @(negedge aclk);
            m_ready <= 1'b1;
            repeat (burst - 1) @(negedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [23:0]       corner;
        logic [MODE_W-1:0] mode;
        bit                no_gaps;
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        s_valid   = 1'b0;
        s_luma_in = '0;
        s_cb_in   = '0;
        s_cr_in   = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: three corner pixels per mode, the first three under the
        // reset value of the mode register, then every code including the unused ones.
        for (int m = 0; m < 8; m++) begin
            if (m > 0) begin
                set_effect_mode(MODE_W'(m));
            end
            for (int k = 0; k < 3; k++) begin
                corner = CORNER_PIXELS[(3 * m + k) % 8];
                send_pixel(corner[23:16], corner[15:8], corner[7:0], pick_gap());
            end
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase < 8) begin
                mode = MODE_W'(7 - phase);
            end else begin
                mode = MODE_W'($urandom_range(0, 7));
            end
            set_effect_mode(mode);
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_PIXELS; i++) begin
                if (i == PHASE_PIXELS / 2 && (phase == 2 || $urandom_range(0, 3) == 0)) begin
                    drain_pipeline();
                end
                send_pixel(pick_sample(), pick_sample(), pick_sample(),
                           no_gaps ? 0 : pick_gap());
            end
        end

        drain_pipeline();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/yce_pkg.sv
src/yuv_color_effect_pixel.sv
sim/yce_pixel_checker.sv
sim/tb_yuv_color_effect_pixel.sv
